[rtl/circular_queue_assert.svh]
// Assertion macros for the circular queue.
`ifndef CIRCULAR_QUEUE_ASSERT_SVH
`define CIRCULAR_QUEUE_ASSERT_SVH

// Property checked on every rising clock edge outside reset
`define CQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define CQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cq_pkg.sv]
`timescale 1ns / 1ps

package cq_pkg;

  // Default geometry
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  // Fixed field widths
  localparam int SLOT_W = 5;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  localparam logic [SLOT_W-1:0] SLOT_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_DRAIN = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_NOQ     = 2'd2
  } status_t;

endpackage

[rtl/cq_ram.sv]
`timescale 1ns / 1ps

module cq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/circular_queue.sv]
`timescale 1ns / 1ps
// Ring-buffer FIFO of signed words, one slot always kept free.
// Input channel: pulse start with in_op / in_value while busy is low; the
// word is taken on that rising edge. busy stays low: a new word may be
// issued every cycle.
// Result channel: exactly one result per word, shown for a single cycle
// with out_valid high, in the cycle after the word was taken. The receiver
// cannot stall; it must capture the result in that cycle.
// Throughput is one word per cycle. Results are registered, dequeue and
// peek data in the registered read port of the ring memory, pointers and
// flags in registers beside it.
// Configuration: cfg_we with cfg_wdata sets the slot count and clears both
// pointers; only write while no result is outstanding. A slot count of 0
// disables the queue, a count above DEPTH is treated as DEPTH.
// Reset (synchronous, rst_n low): slot count 16, pointers at zero, no
// result pending. The ring memory itself is not cleared and needs no
// clearing pass; entries are only read after being written.
module circular_queue
  import cq_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int DATA_W = DATA_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input words
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [DATA_W-1:0] in_value,
  // results
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  output logic [OCC_W-1:0]         out_occupancy,
  // configuration
  input  logic                     cfg_we,
  input  logic [SLOT_W-1:0]        cfg_wdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [SLOT_W-1:0] slot_r;

  logic              out_valid_r;
  logic              sel_mem_r, sel_mem_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  status_t           status_r, status_nxt;
  logic              empty_r, empty_nxt;
  logic              full_r, full_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  logic              accept;
  logic [CNT_W-1:0]  n;
  logic              q_empty, q_full;
  logic [CNT_W:0]    occ_pre, occ_post;
  logic [CNT_W-1:0]  tail_p1, head_p1, tail_nxt_p1;
  logic [PTR_W-1:0]  tail_inc, head_inc, tail_nxt_inc;
  logic              ram_we;
  logic [DATA_W-1:0] ram_rdata;
  op_t               op;

  assign accept = start && !busy;
  assign busy   = 1'b0;
  assign op     = op_t'(in_op);

  // configured slot count, saturated at the ring depth
  always_comb begin
    if (32'(slot_r) > 32'(DEPTH)) begin
      n = CNT_W'(DEPTH);
    end else begin
      n = CNT_W'(slot_r);
    end
  end

  // pointer increments with wrap at n
  always_comb begin
    tail_p1  = CNT_W'(tail_r) + CNT_W'(1);
    head_p1  = CNT_W'(head_r) + CNT_W'(1);
    tail_inc = (tail_p1 == n) ? '0 : tail_p1[PTR_W-1:0];
    head_inc = (head_p1 == n) ? '0 : head_p1[PTR_W-1:0];
  end

  // state before the operation
  always_comb begin
    q_empty = (head_r == tail_r);
    q_full  = (tail_inc == head_r);
    if (tail_r >= head_r) begin
      occ_pre = (CNT_W+1)'(tail_r) - (CNT_W+1)'(head_r);
    end else begin
      occ_pre = (CNT_W+1)'(tail_r) + (CNT_W+1)'(n) - (CNT_W+1)'(head_r);
    end
  end

  // operation decode
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    ram_we      = 1'b0;
    sel_mem_nxt = 1'b0;
    data_nxt    = '0;
    status_nxt  = STAT_DONE;
    case (op)
      OP_ENQ: begin
        if (q_full) begin
          status_nxt = STAT_REFUSED;
        end else begin
          ram_we   = accept && (n != '0);
          tail_nxt = tail_inc;
        end
      end
      OP_DEQ: begin
        if (q_empty) begin
          status_nxt = STAT_REFUSED;
          data_nxt   = '1;
        end else begin
          sel_mem_nxt = 1'b1;
          head_nxt    = head_inc;
        end
      end
      OP_PEEK: begin
        if (q_empty) begin
          status_nxt = STAT_REFUSED;
          data_nxt   = '1;
        end else begin
          sel_mem_nxt = 1'b1;
        end
      end
      OP_DRAIN: begin
        head_nxt = tail_r;
      end
      default: begin
        head_nxt = head_r;
      end
    endcase
  end

  // state after the operation
  always_comb begin
    tail_nxt_p1  = CNT_W'(tail_nxt) + CNT_W'(1);
    tail_nxt_inc = (tail_nxt_p1 == n) ? '0 : tail_nxt_p1[PTR_W-1:0];
    empty_nxt    = (head_nxt == tail_nxt);
    full_nxt     = (tail_nxt_inc == head_nxt);
    if (tail_nxt >= head_nxt) begin
      occ_post = (CNT_W+1)'(tail_nxt) - (CNT_W+1)'(head_nxt);
    end else begin
      occ_post = (CNT_W+1)'(tail_nxt) + (CNT_W+1)'(n) - (CNT_W+1)'(head_nxt);
    end
    occ_nxt = (op == OP_DRAIN) ? OCC_W'(occ_pre) : OCC_W'(occ_post);
  end

  // ring memory; read address is the head, data appears with the result
  cq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_value),
    .re    (accept),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // pointers, slot count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      slot_r      <= SLOT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (cfg_we) begin
        slot_r <= cfg_wdata;
        head_r <= '0;
        tail_r <= '0;
      end else if (accept && (n != '0)) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (n == '0) begin
        sel_mem_r <= 1'b0;
        data_r    <= '1;
        status_r  <= STAT_NOQ;
        empty_r   <= 1'b1;
        full_r    <= 1'b0;
        occ_r     <= '0;
      end else begin
        sel_mem_r <= sel_mem_nxt;
        data_r    <= data_nxt;
        status_r  <= status_nxt;
        empty_r   <= empty_nxt;
        full_r    <= full_nxt;
        occ_r     <= occ_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = sel_mem_r ? ram_rdata : data_r;
  assign out_status    = status_r;
  assign out_is_empty  = empty_r;
  assign out_is_full   = full_r;
  assign out_occupancy = occ_r;

  // checks
`include "circular_queue_assert.svh"

  `CQ_ASSERT(a_head_range, (n == '0) || (CNT_W'(head_r) < n), "head pointer beyond slot count")
  `CQ_ASSERT(a_tail_range, (n == '0) || (CNT_W'(tail_r) < n), "tail pointer beyond slot count")
  `CQ_ASSERT_NEXT(a_noq_result, accept && (n == '0), out_valid && (status_r == STAT_NOQ) && out_is_empty, "no-queue result missing")
  `CQ_ASSERT_NEXT(a_drain_empty, accept && (n != '0) && (op == OP_DRAIN), out_is_empty && (head_r == tail_r), "drain left words behind")

endmodule

[sim/cq_checker.sv]
`timescale 1ns / 1ps

// Watches the word and result channels of the circular queue, keeps its own
// copy of the ring and pointers, and compares every result with the oldest
// prediction.
module cq_checker
  import cq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [OP_W-1:0]              in_op,
  input  logic signed [DATA_W_DEF-1:0] in_value,
  input  logic                         out_valid,
  input  logic signed [DATA_W_DEF-1:0] out_data,
  input  logic [STAT_W-1:0]            out_status,
  input  logic                         out_is_empty,
  input  logic                         out_is_full,
  input  logic [OCC_W-1:0]             out_occupancy,
  input  logic                         cfg_we,
  input  logic [SLOT_W-1:0]            cfg_wdata,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic signed [DATA_W_DEF-1:0] data;
    status_t                      status;
    logic                         is_empty;
    logic                         is_full;
    logic [OCC_W-1:0]             occupancy;
  } queue_result_t;

  localparam logic signed [DATA_W_DEF-1:0] ALL_ONES = -1;

  // mirrored block state
  logic signed [DATA_W_DEF-1:0] ring [DEPTH_DEF];
  logic [SLOT_W-1:0]            slots;
  int                           head_ptr;
  int                           tail_ptr;

  queue_result_t queued_results[$];
  queue_result_t want;
  int            mismatches;

  // Works out the result of one word and moves the mirrored pointers on
  function automatic queue_result_t apply_queue_op(op_t op,
                                                   logic signed [DATA_W_DEF-1:0] value);
    queue_result_t res;
    int n;
    int held_before;
    n = (slots > DEPTH_DEF) ? DEPTH_DEF : int'(slots);
    res = '0;
    if (n == 0) begin
      res.data = ALL_ONES;
      res.status = STAT_NOQ;
      res.is_empty = 1'b1;
      return res;
    end
    res.status = STAT_DONE;
    held_before = (tail_ptr + n - head_ptr) % n;
    case (op)
      OP_ENQ: begin
        if ((tail_ptr + 1) % n == head_ptr) begin
          res.status = STAT_REFUSED;
        end else begin
          ring[tail_ptr] = value;
          tail_ptr = (tail_ptr + 1) % n;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (head_ptr == tail_ptr) begin
          res.status = STAT_REFUSED;
          res.data = ALL_ONES;
        end else begin
          res.data = ring[head_ptr];
          if (op == OP_DEQ) head_ptr = (head_ptr + 1) % n;
        end
      end
      default: begin
        head_ptr = tail_ptr;
      end
    endcase
    res.is_empty = (head_ptr == tail_ptr);
    res.is_full = ((tail_ptr + 1) % n == head_ptr);
    // drain reports what was held before it emptied the queue
    res.occupancy = (op == OP_DRAIN) ? held_before[OCC_W-1:0]
                                     : OCC_W'((tail_ptr + n - head_ptr) % n);
    return res;
  endfunction

  // Results first, then register writes, then the word taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      slots = SLOT_RESET;
      head_ptr = 0;
      tail_ptr = 0;
      queued_results.delete();
    end else begin
      mismatches = 0;
      if (out_valid) begin
        if (queued_results.size() == 0) begin
          $error("result with nothing outstanding: data %0d status %0d",
                 out_data, out_status);
          mismatches++;
        end else begin
          want = queued_results.pop_front();
          if (out_data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, out_data);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_is_empty);
            mismatches++;
          end
          if (out_is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, out_is_full);
            mismatches++;
          end
          if (out_occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_occupancy);
            mismatches++;
          end
        end
      end
      if (mismatches != 0) begin
        errors <= errors + mismatches;
      end
      if (cfg_we) begin
        slots = cfg_wdata;
        head_ptr = 0;
        tail_ptr = 0;
      end
      if (start && !busy) begin
        queued_results.push_back(apply_queue_op(op_t'(in_op), in_value));
      end
    end
    pending = queued_results.size();
  end

  initial errors = 0;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cq_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [OP_W-1:0]              in_op;
  logic signed [DATA_W_DEF-1:0] in_value;
  logic                         out_valid;
  logic signed [DATA_W_DEF-1:0] out_data;
  logic [STAT_W-1:0]            out_status;
  logic                         out_is_empty;
  logic                         out_is_full;
  logic [OCC_W-1:0]             out_occupancy;
  logic                         cfg_we;
  logic [SLOT_W-1:0]            cfg_wdata;

  int errors;
  int pending;
  int cycle_count;
  int words_sent;
  int slot_writes;
  bit gaps_on;

  circular_queue uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full),
    .out_occupancy(out_occupancy),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  cq_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full),
    .out_occupancy(out_occupancy),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .errors       (errors),
    .pending      (pending)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Issue one word, with random idle cycles ahead of it while gaps are on
  task automatic send_word(op_t op, logic signed [DATA_W_DEF-1:0] value);
    while (gaps_on && $urandom_range(99) < 27) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_value <= value;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // Slot count is only written once every result is back
  task automatic write_slots(logic [SLOT_W-1:0] count);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we <= 1'b0;
    slot_writes++;
  endtask

  function automatic logic signed [DATA_W_DEF-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom();
    endcase
  endfunction

  // One random phase at a given slot count and operation mix
  task automatic run_phase(logic [SLOT_W-1:0] count, int words, int enq_pct, int drain_pct);
    int r;
    write_slots(count);
    repeat (words) begin
      r = $urandom_range(99);
      if (r < drain_pct) send_word(OP_DRAIN, pick_value());
      else if (r < drain_pct + enq_pct) send_word(OP_ENQ, pick_value());
      else if ($urandom_range(2) == 0) send_word(OP_PEEK, pick_value());
      else send_word(OP_DEQ, pick_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_ENQ;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cycle_count = 0;
    words_sent = 0;
    slot_writes = 0;
    gaps_on = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty queue at reset size, field extremes, drain of a part-filled queue
    send_word(OP_PEEK, '0);
    send_word(OP_DEQ, '0);
    send_word(OP_ENQ, 32'sh8000_0000);
    send_word(OP_ENQ, 32'sh7fff_ffff);
    send_word(OP_ENQ, '0);
    send_word(OP_ENQ, -1);
    send_word(OP_PEEK, '0);
    send_word(OP_DEQ, '0);
    send_word(OP_DRAIN, '0);
    send_word(OP_DEQ, '0);
    // three slots: full, refused, emptied
    write_slots(5'd3);
    send_word(OP_ENQ, 32'shaaaa_aaaa);
    send_word(OP_ENQ, 32'sh5555_5555);
    send_word(OP_ENQ, 32'sh1234_5678);
    send_word(OP_DEQ, '0);
    send_word(OP_DEQ, '0);
    send_word(OP_DRAIN, '0);
    // no queue configured
    write_slots(5'd0);
    send_word(OP_ENQ, 32'sh0000_0001);
    send_word(OP_DEQ, '0);
    send_word(OP_PEEK, '0);
    send_word(OP_DRAIN, '0);
    // single slot: always empty and full at once
    write_slots(5'd1);
    send_word(OP_ENQ, 32'sh0000_0002);
    send_word(OP_PEEK, '0);
    send_word(OP_DEQ, '0);
    // count above the ring depth saturates
    write_slots(5'd31);
    send_word(OP_ENQ, 32'sh0000_0003);
    send_word(OP_DRAIN, '0);

    // random phases; the third runs back to back with no idle cycles
    run_phase(5'd16, 85, 65, 3);
    run_phase(5'd2, 85, 45, 5);
    gaps_on = 1'b0;
    run_phase(5'd5, 85, 50, 4);
    gaps_on = 1'b1;
    run_phase(5'd16, 85, 40, 2);
    run_phase(5'd8, 85, 55, 6);
    run_phase(5'd3, 85, 50, 5);
    run_phase(SLOT_W'($urandom_range(17, 31)), 85, 60, 3);
    run_phase(5'd0, 40, 40, 10);
    run_phase(5'd1, 40, 40, 10);
    run_phase(5'd16, 85, 70, 2);
    run_phase(SLOT_W'($urandom_range(0, 31)), 85, 50, 5);

    // drain the pipeline and finish
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("tb: %0d words over %0d slot-count settings, reset size included",
             words_sent, slot_writes + 1);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cq_pkg.sv
rtl/cq_ram.sv
rtl/circular_queue.sv
sim/cq_checker.sv
sim/testbench.sv
